// ----- rtl/artdmx_pkg.sv -----
// artdmx_pkg: request/response payload types, queue entry type and ArtDmx header constants
// shared by the packetizer front, queue, back and top level; no dependencies
package artdmx_pkg;

   localparam int HEADER_BYTES = 18;
   localparam int CPF_W        = 7;    // holds a fixture width up to 64
   localparam int BYTE_CNT_W   = 7;    // header + widest fixture + pad
   localparam int LEN_EVEN_W   = 11;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] ART_OPCODE   = 16'h5000;
   localparam logic [15:0] PROT_VERSION = 16'h000e;
   localparam logic [7:0]  SEQ_LAST     = 8'hff;

   localparam logic [1:0] CSR_START_UNIVERSE = 2'd0;
   localparam logic [1:0] CSR_WHITE_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_CHANNELS       = 2'd2;

   typedef struct packed {
      logic        first_of_frame;
      logic [15:0] frame_led_count;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  white;
   } req_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       packet_end;
      logic       item_end;
   } rsp_type;

   // one accepted led, fully classified by the front
   typedef struct packed {
      logic                  header;
      logic [7:0]            seq;
      logic [14:0]           universe;
      logic [LEN_EVEN_W-1:0] len_even;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [7:0]            white;
      logic                  white_enable;
      logic                  packet_end;
      logic [BYTE_CNT_W-1:0] last_idx;
   } desc_type;

   function automatic logic [7:0] header_byte(logic [4:0] idx, logic [7:0] seq,
                                              logic [14:0] uni, logic [LEN_EVEN_W-1:0] len);
      logic [7:0] b;
      unique case (idx)
         5'd0:    b = 8'h41;
         5'd1:    b = 8'h72;
         5'd2:    b = 8'h74;
         5'd3:    b = 8'h2d;
         5'd4:    b = 8'h4e;
         5'd5:    b = 8'h65;
         5'd6:    b = 8'h74;
         5'd7:    b = 8'h00;
         5'd8:    b = ART_OPCODE[7:0];
         5'd9:    b = ART_OPCODE[15:8];
         5'd10:   b = PROT_VERSION[15:8];
         5'd11:   b = PROT_VERSION[7:0];
         5'd12:   b = seq;
         5'd13:   b = 8'h00;
         5'd14:   b = uni[7:0];
         5'd15:   b = {1'b0, uni[14:8]};
         5'd16:   b = 8'(len[LEN_EVEN_W-1:8]);
         5'd17:   b = len[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/artdmx_front.sv -----
// artdmx_front: config registers, frame/packet state and classification of each request
// into a queue entry; depends on artdmx_pkg
module artdmx_front #(
   parameter int MAX_DMX_CHANNELS  = 512,
   parameter int MAX_FIXTURE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  artdmx_pkg::req_type req_payload,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [14:0]         csr_write_data,
   input  logic                queue_full,
   output logic                push,
   output artdmx_pkg::desc_type push_desc
);
   import artdmx_pkg::*;

   localparam int FPP_W  = $clog2(MAX_DMX_CHANNELS + 1);
   localparam int TIDX_W = $clog2(MAX_FIXTURE_WIDTH + 1);
   localparam int PROD_W = (FPP_W + CPF_W > 10) ? FPP_W + CPF_W : 10;

   logic [14:0] start_universe_ff;
   logic        white_enable_ff;
   logic [5:0]  channels_ff;

   logic [7:0]  seq_ff, seq_in;
   logic [14:0] universe_ff, universe_in;
   logic [15:0] leds_rem_ff, leds_rem_in;
   logic [9:0]  chan_idx_ff, chan_idx_in;
   logic [9:0]  pkt_len_ff, pkt_len_in;

   logic [FPP_W-1:0] fpp_tab [0:MAX_FIXTURE_WIDTH];

   // leds per packet for every fixture width, at least one
   for (genvar w = 0; w <= MAX_FIXTURE_WIDTH; w++) begin : g_fpp
      localparam int FppRaw = MAX_DMX_CHANNELS / ((w < 3) ? 3 : w);
      assign fpp_tab[w] = (FppRaw == 0) ? FPP_W'(1) : FPP_W'(FppRaw);
   end

   logic             accept;
   logic [CPF_W-1:0] led_ch, cpf;
   logic [15:0]      rem_start;
   logic [14:0]      uni_start;
   logic [7:0]       seq_next;
   logic [9:0]       ci_start;
   logic             active;
   logic             hdr;
   logic [FPP_W-1:0] fpp, leds;
   logic [PROD_W-1:0] prod;
   logic [9:0]       plen;
   logic [LEN_EVEN_W-1:0] len_even;
   logic [10:0]      pos;
   logic [15:0]      rem_after;
   logic             last;
   logic             pad;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      led_ch = white_enable_ff ? CPF_W'(4) : CPF_W'(3);
      cpf    = CPF_W'(channels_ff);
      if (cpf < led_ch) begin
         cpf = led_ch;
      end
      if (cpf > CPF_W'(MAX_FIXTURE_WIDTH)) begin
         cpf = CPF_W'(MAX_FIXTURE_WIDTH);
      end
      fpp = fpp_tab[cpf[TIDX_W-1:0]];

      seq_next  = seq_ff;
      uni_start = universe_ff;
      rem_start = leds_rem_ff;
      ci_start  = chan_idx_ff;
      active    = leds_rem_ff != 16'd0;
      if (req_payload.first_of_frame) begin
         seq_next  = (seq_ff == 8'd0 || seq_ff >= SEQ_LAST) ? 8'd1 : seq_ff + 8'd1;
         uni_start = start_universe_ff;
         rem_start = (req_payload.frame_led_count == 16'd0) ? 16'd1
                                                            : req_payload.frame_led_count;
         ci_start  = 10'd0;
         active    = 1'b1;
      end

      hdr  = ci_start == 10'd0;
      leds = (rem_start < 16'(fpp)) ? FPP_W'(rem_start) : fpp;
      prod = PROD_W'(leds) * PROD_W'(cpf);
      plen = hdr ? prod[9:0] : pkt_len_ff;
      len_even = (LEN_EVEN_W'(plen) + LEN_EVEN_W'(1)) & ~LEN_EVEN_W'(1);

      pos       = 11'(ci_start) + 11'(cpf);
      rem_after = rem_start - 16'd1;
      last      = (rem_after == 16'd0) || (pos >= 11'(plen));
      pad       = last && plen[0];

      push = accept && active;

      push_desc.header       = hdr;
      push_desc.seq          = seq_next;
      push_desc.universe     = uni_start;
      push_desc.len_even     = len_even;
      push_desc.red          = req_payload.red;
      push_desc.green        = req_payload.green;
      push_desc.blue         = req_payload.blue;
      push_desc.white        = req_payload.white;
      push_desc.white_enable = white_enable_ff;
      push_desc.packet_end   = last;
      push_desc.last_idx     = (hdr ? BYTE_CNT_W'(HEADER_BYTES) : BYTE_CNT_W'(0))
                               + BYTE_CNT_W'(cpf) + BYTE_CNT_W'(pad) - BYTE_CNT_W'(1);

      seq_in      = seq_ff;
      universe_in = universe_ff;
      leds_rem_in = leds_rem_ff;
      chan_idx_in = chan_idx_ff;
      pkt_len_in  = pkt_len_ff;
      if (push) begin
         seq_in      = seq_next;
         leds_rem_in = rem_after;
         pkt_len_in  = plen;
         if (last) begin
            chan_idx_in = 10'd0;
            universe_in = uni_start + 15'd1;
         end else begin
            chan_idx_in = pos[9:0];
            universe_in = uni_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_universe_ff <= 15'd1;
         white_enable_ff   <= 1'b0;
         channels_ff       <= 6'd3;
         seq_ff            <= 8'd0;
         universe_ff       <= 15'd0;
         leds_rem_ff       <= 16'd0;
         chan_idx_ff       <= 10'd0;
         pkt_len_ff        <= 10'd0;
      end else begin
         seq_ff      <= seq_in;
         universe_ff <= universe_in;
         leds_rem_ff <= leds_rem_in;
         chan_idx_ff <= chan_idx_in;
         pkt_len_ff  <= pkt_len_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_START_UNIVERSE: start_universe_ff <= csr_write_data;
               CSR_WHITE_ENABLE:   white_enable_ff   <= csr_write_data[0];
               CSR_CHANNELS:       channels_ff       <= csr_write_data[5:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- rtl/artdmx_queue.sv -----
// artdmx_queue: short queue of classified leds between front and back
// depends on artdmx_pkg
module artdmx_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  artdmx_pkg::desc_type push_desc,
   input  logic                 pop,
   output artdmx_pkg::desc_type head,
   output logic                 empty,
   output logic                 full,
   output logic [artdmx_pkg::QPTR_W:0] count
);
   import artdmx_pkg::*;

   desc_type          entry_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign full  = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/artdmx_back.sv -----
// artdmx_back: walks the queue head byte by byte (header, channels, padding) into
// the registered response stage; depends on artdmx_pkg
module artdmx_back (
   input  logic                 clock,
   input  logic                 reset,
   input  artdmx_pkg::desc_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output artdmx_pkg::rsp_type  rsp_payload
);
   import artdmx_pkg::*;

   logic [BYTE_CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   logic                  out_ready;
   logic                  fire;
   logic                  is_last;
   logic [BYTE_CNT_W-1:0] data_idx;
   logic [7:0]            byte_val;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      fire      = out_ready && !empty;
      is_last   = byte_cnt_ff == head.last_idx;
      pop       = fire && is_last;

      data_idx = byte_cnt_ff - (head.header ? BYTE_CNT_W'(HEADER_BYTES) : BYTE_CNT_W'(0));
      if (head.header && byte_cnt_ff < BYTE_CNT_W'(HEADER_BYTES)) begin
         byte_val = header_byte(byte_cnt_ff[4:0], head.seq, head.universe, head.len_even);
      end else begin
         // past the color channels only zero fill and the odd-length pad remain
         case (data_idx)
            BYTE_CNT_W'(0): byte_val = head.red;
            BYTE_CNT_W'(1): byte_val = head.green;
            BYTE_CNT_W'(2): byte_val = head.blue;
            BYTE_CNT_W'(3): byte_val = head.white_enable ? head.white : 8'h00;
            default:        byte_val = 8'h00;
         endcase
      end

      byte_cnt_in    = byte_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (fire) begin
         byte_cnt_in                = is_last ? '0 : byte_cnt_ff + BYTE_CNT_W'(1);
         rsp_valid_in               = 1'b1;
         rsp_payload_in.packet_byte = byte_val;
         rsp_payload_in.packet_end  = is_last && head.packet_end;
         rsp_payload_in.item_end    = is_last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         byte_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_cnt_ff  <= byte_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/artdmx_dmx_packetizer.sv -----
// artdmx_dmx_packetizer: tracks whether the response channel is part way through the
// bytes of one request, used by the top level checks; depends on artdmx_pkg
module artdmx_dmx_packetizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  artdmx_pkg::rsp_type rsp_payload,
   output logic                mid_item
);
   import artdmx_pkg::*;

   logic mid_item_ff, mid_item_in;

   // high between the first and the last byte of one request's output
   always_comb begin
      mid_item_in = mid_item_ff;
      if (rsp_valid && !rsp_stall) begin
         mid_item_in = !rsp_payload.item_end;
      end
   end

   assign mid_item = mid_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_item_ff <= 1'b0;
      end else begin
         mid_item_ff <= mid_item_in;
      end
   end

endmodule

// ----- rtl/artnet_dmx_packetizer.sv -----
// artnet_dmx_packetizer: top level, front classifier, queue and byte emitter
// depends on artdmx_pkg, artdmx_front, artdmx_queue, artdmx_back, artdmx_dmx_packetizer
//
// Takes one led color per request and emits ArtDmx packets one byte per response.
// The first led of a packet is preceded by the 18-byte header; each led then gives
// its color channels, zero fill up to the fixture width, and on the last led of an odd
// length packet one pad byte. Output runs at one byte per cycle while the response is
// not stalled; a request gives fixture-width bytes (3 to MAX_FIXTURE_WIDTH), plus 18
// when it opens a packet and one more for the pad. The front classifies a request
// combinationally and buffers up to four of them, so requests are taken every cycle
// while the queue has room. Configuration writes apply to requests accepted after them.
module artnet_dmx_packetizer #(
   parameter int MAX_DMX_CHANNELS  = 512,
   parameter int MAX_FIXTURE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  artdmx_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output artdmx_pkg::rsp_type rsp_payload,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [14:0]         csr_write_data
);
   import artdmx_pkg::*;

   logic              push, pop, empty, full, mid_item;
   desc_type          push_desc, head;
   logic [QPTR_W:0]   count;

   artdmx_front #(
      .MAX_DMX_CHANNELS (MAX_DMX_CHANNELS),
      .MAX_FIXTURE_WIDTH(MAX_FIXTURE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .queue_full      (full),
      .push            (push),
      .push_desc       (push_desc)
   );

   artdmx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_desc(push_desc),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full),
      .count    (count)
   );

   artdmx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   artdmx_dmx_packetizer u_track (
      .clock      (clock),
      .reset      (reset),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .mid_item   (mid_item)
   );

   // a packet always closes on the last byte of some request
   a_pkt_end_item_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.packet_end) |-> rsp_payload.item_end)
      else $error("packet_end without item_end");

   // the rest of a request's bytes follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_payload.item_end) |=> rsp_valid)
      else $error("gap inside one request's bytes");

   // while a request is half delivered its bytes sit in the queue or the output stage
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      mid_item |-> (!empty || rsp_valid))
      else $error("request bytes lost in the middle of a request");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue overflow");

endmodule

// ----- tb/artnet_dmx_packetizer_tb.sv -----
// artnet_dmx_packetizer_tb: self-checking bench for the ArtDmx packetizer, with a directed table
// followed by random frames, random idling on both channels and a byte-level predictor
// depends on artdmx_pkg and artnet_dmx_packetizer
module artnet_dmx_packetizer_tb;
   import artdmx_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int DMX_MAX        = 512;
   localparam int FIXTURE_MAX    = 32;
   localparam int SETTLE_CYCLES  = 12;
   localparam int TIMEOUT_CYCLES = 2000000;
   localparam int RAND_PHASES    = 11;
   localparam int WRAP_PHASE     = 5;
   localparam logic [63:0] ART_ID = 64'h4172742d4e657400;

   typedef enum logic { ROW_CFG, ROW_LED } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [14:0]  uni;
      logic         wen;
      logic [5:0]   cpf;
      req_type      led;
      int           typed_len;   // bytes this request must cause, -1 when left to the predictor
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_START_UNIVERSE;
   logic [14:0] csr_write_data = '0;

   // predictor copy of the registers and the framing state
   logic [14:0] cfg_start_uni = 15'd1;
   logic        cfg_white = 1'b0;
   logic [5:0]  cfg_cpf = 6'd3;
   logic [9:0]  dmx_chan_idx = '0;
   logic [14:0] pkt_universe = '0;
   logic [7:0]  frame_seq = '0;
   logic [15:0] leds_left = '0;
   logic [9:0]  decl_len = '0;

   rsp_type     expected_bytes[$];
   int          typed_len_q[$];
   dir_row_type dir_rows[$];
   rsp_type     want;
   int          run_bytes = 0;
   int          errors = 0;
   int          frame_todo = 0;

   artnet_dmx_packetizer #(
      .MAX_DMX_CHANNELS (DMX_MAX),
      .MAX_FIXTURE_WIDTH(FIXTURE_MAX)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 80);
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      rsp_type e;
      e.packet_byte = b;
      e.packet_end  = 1'b0;
      e.item_end    = 1'b0;
      expected_bytes.push_back(e);
   endfunction

   // one led through the framer: pushes the bytes it causes and returns their count
   function automatic int pack_led(input req_type r);
      int          base;
      int          led_ch;
      int          cpf;
      int          fpp;
      int          leds;
      int          pos;
      logic [10:0] len_even;
      rsp_type     tail;
      base   = expected_bytes.size();
      led_ch = cfg_white ? 4 : 3;
      cpf    = cfg_cpf;
      if (cpf < led_ch) cpf = led_ch;
      if (cpf > FIXTURE_MAX) cpf = FIXTURE_MAX;
      if (r.first_of_frame) begin
         if (frame_seq == 8'd0 || frame_seq == SEQ_LAST) frame_seq = 8'd1;
         else frame_seq = frame_seq + 8'd1;
         pkt_universe = cfg_start_uni;
         leds_left    = (r.frame_led_count == 16'd0) ? 16'd1 : r.frame_led_count;
         dmx_chan_idx = '0;
      end else if (leds_left == 16'd0) begin
         return 0;
      end
      if (dmx_chan_idx == 10'd0) begin
         fpp = DMX_MAX / cpf;
         if (fpp == 0) fpp = 1;
         leds = (leds_left < fpp) ? leds_left : fpp;
         decl_len = 10'(leds * cpf);
         len_even = ({1'b0, decl_len} + 11'd1) & ~11'd1;
         for (int i = 0; i < 8; i++) queue_byte(ART_ID[63 - 8 * i -: 8]);
         queue_byte(ART_OPCODE[7:0]);
         queue_byte(ART_OPCODE[15:8]);
         queue_byte(PROT_VERSION[15:8]);
         queue_byte(PROT_VERSION[7:0]);
         queue_byte(frame_seq);
         queue_byte(8'h00);
         queue_byte(pkt_universe[7:0]);
         queue_byte({1'b0, pkt_universe[14:8]});
         queue_byte({5'd0, len_even[10:8]});
         queue_byte(len_even[7:0]);
      end
      queue_byte(r.red);
      queue_byte(r.green);
      queue_byte(r.blue);
      if (cfg_white) queue_byte(r.white);
      for (int i = led_ch; i < cpf; i++) queue_byte(8'h00);
      pos = dmx_chan_idx + cpf;
      leds_left = leds_left - 16'd1;
      if (leds_left == 16'd0 || pos >= decl_len) begin
         if (decl_len[0]) queue_byte(8'h00);
         tail = expected_bytes.pop_back();
         tail.packet_end = 1'b1;
         expected_bytes.push_back(tail);
         dmx_chan_idx = '0;
         pkt_universe = pkt_universe + 15'd1;
      end else begin
         dmx_chan_idx = 10'(pos);
      end
      tail = expected_bytes.pop_back();
      tail.item_end = 1'b1;
      expected_bytes.push_back(tail);
      return expected_bytes.size() - base;
   endfunction

   // random led; opens a new frame when the current one is used up, now and then early
   function automatic req_type next_led();
      req_type     r;
      int          k;
      logic [15:0] cnt;
      r.first_of_frame  = 1'b0;
      r.frame_led_count = 16'($urandom);
      r.red   = 8'($urandom);
      r.green = 8'($urandom);
      r.blue  = 8'($urandom);
      r.white = 8'($urandom);
      if (frame_todo == 0 || $urandom_range(0, 99) < 4) begin
         k = $urandom_range(0, 99);
         if (k < 45) cnt = 16'($urandom_range(0, 3));
         else if (k < 80) cnt = 16'($urandom_range(4, 24));
         else if (k < 93) cnt = 16'($urandom_range(25, 60));
         else cnt = 16'($urandom);
         r.first_of_frame  = 1'b1;
         r.frame_led_count = cnt;
         frame_todo = (cnt == 16'd0) ? 1 : cnt;
      end
      frame_todo--;
      return r;
   endfunction

   function automatic void add_cfg(input logic [14:0] uni, input logic wen, input logic [5:0] cpf);
      dir_row_type d;
      d.kind = ROW_CFG;
      d.uni  = uni;
      d.wen  = wen;
      d.cpf  = cpf;
      d.led  = '0;
      d.typed_len = -1;
      dir_rows.push_back(d);
   endfunction

   function automatic void add_led(input logic first, input logic [15:0] cnt,
                                   input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] w, input int len);
      dir_row_type d;
      d.kind = ROW_LED;
      d.uni  = '0;
      d.wen  = 1'b0;
      d.cpf  = '0;
      d.led  = '{first, cnt, r, g, b, w};
      d.typed_len = len;
      dir_rows.push_back(d);
   endfunction

   task automatic send_led(input req_type r, input int typed, output int n);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      n = pack_led(r);
      if (n > 0) typed_len_q.push_back(typed > 0 ? typed : 0);
   endtask

   // sender holds off until every expected byte is out and the pipe is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [14:0] uni, input logic wen, input logic [5:0] cpf);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_START_UNIVERSE;
      csr_write_data   <= uni;
      @(posedge clock);
      csr_index        <= CSR_WHITE_ENABLE;
      csr_write_data   <= {14'd0, wen};
      @(posedge clock);
      csr_index        <= CSR_CHANNELS;
      csr_write_data   <= {9'd0, cpf};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_start_uni = uni;
      cfg_white     = wen;
      cfg_cpf       = cpf;
   endtask

   // response stall: runs of free flow mixed with stalls of random length
   initial begin : rsp_backpressure
      int   seg;
      logic hold;
      seg  = 0;
      hold = 1'b0;
      forever begin
         @(posedge clock);
         if (seg == 0) begin
            if ($urandom_range(0, 99) < 65) begin
               hold = 1'b0;
               seg  = $urandom_range(1, 40);
            end else begin
               hold = 1'b1;
               seg  = idle_len();
               if (seg == 0) seg = 1;
            end
         end
         rsp_stall <= hold;
         seg--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected response byte %h", rsp_payload.packet_byte);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_payload.packet_byte !== want.packet_byte) begin
               $error("packet_byte expected %h got %h", want.packet_byte, rsp_payload.packet_byte);
               errors++;
            end
            if (rsp_payload.packet_end !== want.packet_end) begin
               $error("packet_end expected %b got %b", want.packet_end, rsp_payload.packet_end);
               errors++;
            end
            if (rsp_payload.item_end !== want.item_end) begin
               $error("item_end expected %b got %b", want.item_end, rsp_payload.item_end);
               errors++;
            end
         end
         run_bytes++;
         if (rsp_payload.item_end === 1'b1) begin
            if (typed_len_q.size() != 0 && typed_len_q[0] > 0 && typed_len_q[0] != run_bytes) begin
               $error("request byte count expected %0d got %0d", typed_len_q[0], run_bytes);
               errors++;
            end
            if (typed_len_q.size() != 0) void'(typed_len_q.pop_front());
            run_bytes = 0;
         end
      end
   end

   initial begin : stimulus
      dir_row_type row;
      req_type     r;
      int          n;
      int          sent;
      int          budget;
      int          k;
      logic [14:0] uni;
      logic        wen;
      logic [5:0]  cpf;

      // reset config: universe 1, rgb, width 3
      add_led(1'b0, 16'd5,     8'h12, 8'h34, 8'h56, 8'h78, 0);   // outside a frame
      add_led(1'b1, 16'd1,     8'h00, 8'h00, 8'h00, 8'hff, 22);  // odd length gets a pad
      add_led(1'b1, 16'd2,     8'hff, 8'hff, 8'hff, 8'h00, 21);
      add_led(1'b0, 16'hffff,  8'h80, 8'h01, 8'h7f, 8'h00, 3);
      add_led(1'b0, 16'd0,     8'h01, 8'h02, 8'h03, 8'h04, 0);   // frame already done
      add_led(1'b1, 16'd0,     8'h0f, 8'hf0, 8'h5a, 8'ha5, 22);  // zero count is one led
      add_led(1'b1, 16'd3,     8'h11, 8'h22, 8'h33, 8'h44, 21);
      add_led(1'b1, 16'd1,     8'h55, 8'h66, 8'h77, 8'h88, 22);  // restart mid frame
      add_led(1'b1, 16'd5,     8'h99, 8'haa, 8'hbb, 8'hcc, 21);
      // config changed with the packet still open, universe at the top
      add_cfg(15'h7fff, 1'b1, 6'd0);
      add_led(1'b0, 16'd0,     8'hde, 8'had, 8'hbe, 8'hef, -1);
      add_led(1'b1, 16'd1,     8'h01, 8'h02, 8'h03, 8'haa, 22);  // universe wraps after this
      add_led(1'b1, 16'd2,     8'hfe, 8'hdc, 8'hba, 8'h98, 22);
      add_led(1'b0, 16'd7,     8'h76, 8'h54, 8'h32, 8'h10, 4);
      // width above the limit, cut to the widest fixture
      add_cfg(15'h0000, 1'b0, 6'd63);
      add_led(1'b1, 16'hffff,  8'hff, 8'h00, 8'hff, 8'h00, 50);
      add_led(1'b0, 16'd0,     8'h00, 8'hff, 8'h00, 8'hff, 32);
      add_led(1'b0, 16'd0,     8'h3c, 8'hc3, 8'h69, 8'h96, 32);
      add_cfg(15'h4321, 1'b0, 6'd5);
      add_led(1'b1, 16'd3,     8'h10, 8'h20, 8'h30, 8'h40, 23);
      add_led(1'b0, 16'd0,     8'h50, 8'h60, 8'h70, 8'h80, 5);
      add_led(1'b0, 16'd0,     8'h90, 8'ha0, 8'hb0, 8'hc0, 6);
      add_cfg(15'h00ff, 1'b1, 6'd32);
      add_led(1'b1, 16'd2,     8'h01, 8'h80, 8'h7f, 8'hfe, 50);
      add_led(1'b0, 16'd0,     8'hc0, 8'h03, 8'h0c, 8'h30, 32);
      add_led(1'b1, 16'h8000,  8'h55, 8'haa, 8'h0f, 8'hf0, 50);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CFG) begin
            settle();
            set_config(row.uni, row.wen, row.cpf);
         end else begin
            send_led(row.led, row.typed_len, n);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         if (ph == 0) begin
            uni = 15'h7fff;
            wen = 1'b1;
            cpf = 6'd63;
         end else if (ph == 1) begin
            uni = 15'h0000;
            wen = 1'b0;
            cpf = 6'd0;
         end else begin
            k = $urandom_range(0, 99);
            if (k < 25) uni = 15'h7fff - 15'($urandom_range(0, 2));
            else if (k < 40) uni = 15'h0000;
            else uni = 15'($urandom_range(0, 32767));
            wen = 1'($urandom_range(0, 1));
            k = $urandom_range(0, 99);
            if (k < 30) cpf = 6'($urandom_range(0, 63));
            else if (k < 60) cpf = 6'($urandom_range(3, 6));
            else if (k < 85) cpf = 6'($urandom_range(17, 31));
            else cpf = 6'd32;
         end
         set_config(uni, wen, cpf);
         // one phase of back-to-back single-led frames walks the sequence through its wrap
         budget = (ph == WRAP_PHASE) ? 260 : 24;
         sent = 0;
         while (sent < budget) begin
            if ($urandom_range(0, 99) < 3) settle();
            if (ph == WRAP_PHASE) begin
               frame_todo = 0;
               r = next_led();
            end else if (frame_todo == 0 && $urandom_range(0, 99) < 8) begin
               r = next_led();
               r.first_of_frame = 1'b0;   // stray led between frames
               frame_todo = 0;
            end else begin
               r = next_led();
            end
            send_led(r, -1, n);
            if (n > 0) sent++;
         end
      end

      settle();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/artdmx_pkg.sv
rtl/artdmx_front.sv
rtl/artdmx_queue.sv
rtl/artdmx_back.sv
rtl/artdmx_dmx_packetizer.sv
rtl/artnet_dmx_packetizer.sv
tb/artnet_dmx_packetizer_tb.sv
